/* src/srmq_pkg.sv */
// Package with the shared constants, types and helper function of the sparse-table RMQ block.
package srmq_pkg;

    localparam int MAX_LENGTH = 1024;
    localparam int VALUE_BITS = 16;
    localparam int LEVELS     = 11;

    localparam int POS_W     = $clog2(MAX_LENGTH);
    localparam int CNT_W     = $clog2(MAX_LENGTH + 1);
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int TBL_DEPTH = LEVELS * MAX_LENGTH;
    localparam int TADDR_W   = $clog2(TBL_DEPTH);

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NO_TABLE = 2'd1,
        STAT_RANGE    = 2'd2
    } stat_t;

    // Read requests toward the two memories and write requests toward the table memory.
    typedef struct packed {
        logic               tbl_we;
        logic [TADDR_W-1:0] tbl_waddr;
        logic [POS_W-1:0]   tbl_wdata;
        logic [TADDR_W-1:0] tbl_raddr_a;
        logic [TADDR_W-1:0] tbl_raddr_b;
        logic [POS_W-1:0]   val_raddr_a;
        logic [POS_W-1:0]   val_raddr_b;
    } mem_req_t;

    // Floor of log2 of a range length, limited to the top level that exists.
    function automatic logic [LVL_W-1:0] floor_log2(input logic [CNT_W-1:0] x);
        int r;
        r = 0;
        for (int i = 0; i < CNT_W; i++) begin
            if (x[i]) begin
                r = i;
            end
        end
        if (r > LEVELS - 1) begin
            r = LEVELS - 1;
        end
        return LVL_W'(r);
    endfunction

endpackage

/* src/srmq_ram.sv */
// Generic memory with one write port and two registered read ports.
module srmq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

/* src/srmq_build.sv */
// Table build sequencer: fills one level after another from the level below it.
module srmq_build (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [srmq_pkg::CNT_W-1:0]            count,
    input  logic [srmq_pkg::POS_W-1:0]            tbl_rdata_a,
    input  logic [srmq_pkg::POS_W-1:0]            tbl_rdata_b,
    input  logic [srmq_pkg::VALUE_BITS-1:0]       val_rdata_a,
    input  logic [srmq_pkg::VALUE_BITS-1:0]       val_rdata_b,
    output srmq_pkg::mem_req_t                    req,
    output logic                                  done
);

    import srmq_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_ISSUE = 3'b010,
        B_DRAIN = 3'b100
    } bstate_t;

    bstate_t            bstate_reg, bstate_next;
    logic [LVL_W-1:0]   level_reg, level_next;
    logic [POS_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   m_reg, m_next;
    logic               s1_valid_reg, s1_valid_next;
    logic               s2_valid_reg, s2_valid_next;
    logic [POS_W-1:0]   s1_idx_reg;
    logic [POS_W-1:0]   s2_idx_reg;
    logic [POS_W-1:0]   s2_a_reg;
    logic [POS_W-1:0]   s2_b_reg;

    logic [POS_W-1:0]   half;
    logic [CNT_W-1:0]   last_idx;
    logic               issue_last;
    logic [LVL_W:0]     lvl_up;
    logic               can_grow;
    logic               drained;
    logic [LVL_W-1:0]   prev_level;

    assign prev_level = level_reg - LVL_W'(1);
    assign half       = {{(POS_W-1){1'b0}}, 1'b1} << prev_level;
    assign last_idx   = m_reg - ({{(CNT_W-1){1'b0}}, 1'b1} << level_reg);
    assign issue_last = ({1'b0, idx_reg} == last_idx);
    assign lvl_up     = {1'b0, level_reg} + (LVL_W+1)'(1);
    assign can_grow   = (lvl_up < (LVL_W+1)'(LEVELS)) && ((m_reg >> lvl_up) != '0);
    assign drained    = !s1_valid_reg && !s2_valid_reg;
    assign done       = (bstate_reg == B_DRAIN) && drained && !can_grow;

    always_comb
    begin
        req.tbl_raddr_a = {prev_level, idx_reg};
        req.tbl_raddr_b = {prev_level, idx_reg + half};
        // Positions read from the level below select the two values to compare.
        req.val_raddr_a = tbl_rdata_a;
        req.val_raddr_b = tbl_rdata_b;
        req.tbl_we      = s2_valid_reg;
        req.tbl_waddr   = {level_reg, s2_idx_reg};
        req.tbl_wdata   = (val_rdata_a <= val_rdata_b) ? s2_a_reg : s2_b_reg;
    end

    always_comb
    begin
        bstate_next   = bstate_reg;
        level_next    = level_reg;
        idx_next      = idx_reg;
        m_next        = m_reg;
        s1_valid_next = (bstate_reg == B_ISSUE);
        s2_valid_next = s1_valid_reg;
        unique case (bstate_reg)
            B_IDLE:
            begin
                if (start) begin
                    m_next      = count;
                    level_next  = '0;
                    bstate_next = B_DRAIN;
                end
            end
            B_ISSUE:
            begin
                idx_next = idx_reg + POS_W'(1);
                if (issue_last) begin
                    bstate_next = B_DRAIN;
                end
            end
            B_DRAIN:
            begin
                // A new level starts only after every write of the last one landed.
                if (drained) begin
                    if (can_grow) begin
                        level_next  = lvl_up[LVL_W-1:0];
                        idx_next    = '0;
                        bstate_next = B_ISSUE;
                    end else begin
                        bstate_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                bstate_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bstate_reg   <= B_IDLE;
            level_reg    <= '0;
            idx_reg      <= '0;
            m_reg        <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            bstate_reg   <= bstate_next;
            level_reg    <= level_next;
            idx_reg      <= idx_next;
            m_reg        <= m_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= idx_reg;
        s2_idx_reg <= s1_idx_reg;
        s2_a_reg   <= tbl_rdata_a;
        s2_b_reg   <= tbl_rdata_b;
    end

endmodule

/* src/sparse_table_range_min_top.sv */
// Top level of the sparse-table range minimum block: load, build and query control.
//
// Input beats arrive on the s_axis channel. tuser carries the function: a load beat
// writes one array element, and a load beat with tlast high also closes the array and
// starts the table build. A load beat after a finished build begins a new array. A
// query beat names two positions in tdata, in either order.
// Every query yields exactly one beat on m_axis with the position and value of the
// leftmost minimum and a status in tuser: ok, no table built yet, or a position
// outside the loaded array (position and value are then zero). Loads yield no beat.
// A query passes through the states for the level select and the two table reads, for
// the two value reads and for the compare, and its result then enters the output
// register; no new beat is accepted until it has. The build fills each level in turn
// from the one below it and lets every write of a level land before it starts the next;
// no beat is accepted meanwhile.
// The result sits in an output register, so the next beat is accepted while a result
// still waits; a query that finishes while that register is full holds until m_axis
// takes the old beat. Reset clears the element count and the built flag; the memories
// need no clearing, as only entries written by the current load and build are read.
module sparse_table_range_min_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // elem_value [15:0], left_pos [25:16], right_pos [35:26], zero [39:36]
    input  logic [srmq_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic                              s_axis_tlast,
    // func [0]
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // min_pos [9:0], min_value [25:10], zero [31:26]
    output logic [srmq_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // status [1:0]
    output logic [1:0]                        m_axis_tuser
);

    import srmq_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_BUILD = 5'b00010,
        ST_QADDR = 5'b00100,
        ST_QREAD = 5'b01000,
        ST_QCMP  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   ready_reg, ready_next;
    logic                   out_valid_reg, out_valid_next;
    logic [POS_W-1:0]       lo_reg, hi_reg;
    stat_t                  qstat_reg;
    logic [POS_W-1:0]       qa_reg, qb_reg;
    logic [POS_W-1:0]       out_pos_reg;
    logic [VALUE_BITS-1:0]  out_val_reg;
    stat_t                  out_stat_reg;

    logic [VALUE_BITS-1:0]  in_value;
    logic [POS_W-1:0]       in_left, in_right;
    logic                   accept, is_load, is_query;
    logic [CNT_W-1:0]       base_cnt, load_cnt;
    logic                   has_room;
    stat_t                  in_stat;

    logic [CNT_W-1:0]       span, blk;
    logic [CNT_W-1:0]       rstart;
    logic [LVL_W-1:0]       lvl;
    logic                   load_out;
    logic                   pick_a;

    mem_req_t               q_req, b_req, mem_req;
    logic                   build_start, build_done;
    logic [POS_W-1:0]       tbl_rdata_a, tbl_rdata_b;
    logic [VALUE_BITS-1:0]  val_rdata_a, val_rdata_b;

    assign in_value = s_axis_tdata[15:0];
    assign in_left  = s_axis_tdata[25:16];
    assign in_right = s_axis_tdata[35:26];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_load       = accept && (s_axis_tuser == FUNC_LOAD);
    assign is_query      = accept && (s_axis_tuser == FUNC_QUERY);

    // A load after a build restarts the array at position zero.
    assign base_cnt    = ready_reg ? '0 : count_reg;
    assign has_room    = (base_cnt < CNT_W'(MAX_LENGTH));
    assign load_cnt    = has_room ? base_cnt + CNT_W'(1) : base_cnt;
    assign build_start = is_load && s_axis_tlast;

    always_comb
    begin
        if (!ready_reg) begin
            in_stat = STAT_NO_TABLE;
        end else if (({1'b0, in_left} >= count_reg) || ({1'b0, in_right} >= count_reg)) begin
            in_stat = STAT_RANGE;
        end else begin
            in_stat = STAT_OK;
        end
    end

    // Two blocks of size 2^k cover the range: one from the low end, one to the high end.
    assign span   = {1'b0, hi_reg} - {1'b0, lo_reg} + CNT_W'(1);
    assign lvl    = floor_log2(span);
    assign blk    = {{(CNT_W-1){1'b0}}, 1'b1} << lvl;
    assign rstart = {1'b0, hi_reg} + CNT_W'(1) - blk;

    always_comb
    begin
        q_req.tbl_we      = is_load && has_room;
        q_req.tbl_waddr   = {{LVL_W{1'b0}}, base_cnt[POS_W-1:0]};
        q_req.tbl_wdata   = base_cnt[POS_W-1:0];
        q_req.tbl_raddr_a = {lvl, lo_reg};
        q_req.tbl_raddr_b = {lvl, rstart[POS_W-1:0]};
        if (state_reg == ST_QREAD) begin
            q_req.val_raddr_a = tbl_rdata_a;
            q_req.val_raddr_b = tbl_rdata_b;
        end else begin
            q_req.val_raddr_a = qa_reg;
            q_req.val_raddr_b = qb_reg;
        end
    end

    assign mem_req  = (state_reg == ST_BUILD) ? b_req : q_req;
    assign pick_a   = (val_rdata_a <= val_rdata_b);
    assign load_out = (state_reg == ST_QCMP) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ready_next     = ready_reg;
        out_valid_next = (out_valid_reg && !m_axis_tready) || load_out;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_load) begin
                    count_next = load_cnt;
                    ready_next = 1'b0;
                    if (s_axis_tlast) begin
                        state_next = ST_BUILD;
                    end
                end else if (is_query) begin
                    state_next = ST_QADDR;
                end
            end
            ST_BUILD:
            begin
                if (build_done) begin
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_QADDR:
            begin
                state_next = ST_QREAD;
            end
            ST_QREAD:
            begin
                state_next = ST_QCMP;
            end
            ST_QCMP:
            begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_query) begin
            lo_reg    <= (in_left > in_right) ? in_right : in_left;
            hi_reg    <= (in_left > in_right) ? in_left : in_right;
            qstat_reg <= in_stat;
        end
        if (state_reg == ST_QREAD) begin
            qa_reg <= tbl_rdata_a;
            qb_reg <= tbl_rdata_b;
        end
        if (load_out) begin
            out_stat_reg <= qstat_reg;
            if (qstat_reg == STAT_OK) begin
                out_pos_reg <= pick_a ? qa_reg : qb_reg;
                out_val_reg <= pick_a ? val_rdata_a : val_rdata_b;
            end else begin
                out_pos_reg <= '0;
                out_val_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - VALUE_BITS - POS_W)'(0), out_val_reg, out_pos_reg};
    assign m_axis_tuser  = out_stat_reg;

    srmq_build u_build (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (build_start),
        .count       (load_cnt),
        .tbl_rdata_a (tbl_rdata_a),
        .tbl_rdata_b (tbl_rdata_b),
        .val_rdata_a (val_rdata_a),
        .val_rdata_b (val_rdata_b),
        .req         (b_req),
        .done        (build_done)
    );

    srmq_ram #(
        .WIDTH (POS_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl_ram (
        .clk     (clk),
        .we      (mem_req.tbl_we),
        .waddr   (mem_req.tbl_waddr),
        .wdata   (mem_req.tbl_wdata),
        .raddr_a (mem_req.tbl_raddr_a),
        .raddr_b (mem_req.tbl_raddr_b),
        .rdata_a (tbl_rdata_a),
        .rdata_b (tbl_rdata_b)
    );

    srmq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_LENGTH)
    ) u_val_ram (
        .clk     (clk),
        .we      (is_load && has_room),
        .waddr   (base_cnt[POS_W-1:0]),
        .wdata   (in_value),
        .raddr_a (mem_req.val_raddr_a),
        .raddr_b (mem_req.val_raddr_b),
        .rdata_a (val_rdata_a),
        .rdata_b (val_rdata_b)
    );

endmodule

/* src/srmq_checker.sv */
// Port-level checker for the sparse-table RMQ block and its bind to the top level.
module srmq_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic                              s_axis_tlast,
    input  logic                              s_axis_tuser,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [srmq_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input  logic [1:0]                        m_axis_tuser
);

    import srmq_pkg::*;

    // A result that waits keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // Error results carry neither position nor value.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != STAT_OK) |-> (m_axis_tdata == '0))
        else $error("error result with nonzero data");

    // Only the three defined status codes appear.
    a_stat_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == STAT_OK) || (m_axis_tuser == STAT_NO_TABLE)
            || (m_axis_tuser == STAT_RANGE))
        else $error("undefined status code");

    // An accepted query blocks the input while it runs.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_QUERY) |=> !s_axis_tready)
        else $error("input accepted right after a query");

    // A closing load starts the build, which blocks the input.
    a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_LOAD) && s_axis_tlast
            |=> !s_axis_tready)
        else $error("input accepted right after the last load beat");

endmodule

bind sparse_table_range_min_top srmq_checker u_srmq_checker (.*);
